[src/tnfs_pkg.sv]
// ----------------------------------------------------------------------------
// tnfs_pkg
// Shared types, command and status codes for the reply deframer.
// ----------------------------------------------------------------------------
package tnfs_pkg;

	localparam int IO_CHUNK    = 1024;
	localparam int MSG_CAP     = IO_CHUNK + 8;
	localparam int ENTRY_FIXED = 13;
	localparam int OFF_W       = 11;
	localparam int CNT_W       = 16;

	localparam logic [7:0] ST_OK   = 8'h00;
	localparam logic [7:0] ST_BUSY = 8'h07;
	localparam logic [7:0] ST_EOF  = 8'h21;

	localparam logic [7:0] CMD_MOUNT    = 8'h00;
	localparam logic [7:0] CMD_OPENDIR  = 8'h10;
	localparam logic [7:0] CMD_READDIR  = 8'h11;
	localparam logic [7:0] CMD_OPENDIRX = 8'h17;
	localparam logic [7:0] CMD_READDIRX = 8'h18;
	localparam logic [7:0] CMD_READ     = 8'h21;
	localparam logic [7:0] CMD_WRITE    = 8'h22;
	localparam logic [7:0] CMD_LSEEK    = 8'h25;
	localparam logic [7:0] CMD_OPEN     = 8'h29;

	localparam logic [1:0] RES_NONE = 2'd0;
	localparam logic [1:0] RES_DONE = 2'd1;
	localparam logic [1:0] RES_OVF  = 2'd2;

	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_TAIL   = 6'b000010,
		PH_DATA   = 6'b000100,
		PH_NAME   = 6'b001000,
		PH_XHDR   = 6'b010000,
		PH_ENTRY  = 6'b100000
	} tnfs_phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [7:0] command;
	} tnfs_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [OFF_W-1:0] frame_offset;
		logic             frame_last;
		logic [1:0]       frame_result;
		logic [7:0]       reply_status;
	} tnfs_result_t;

	typedef struct packed {
		tnfs_phase_t      phase;
		logic [CNT_W-1:0] remaining;
		logic [1:0]       res;
	} tnfs_step_t;

	function automatic logic [2:0] tail_length(input logic [7:0] cmd);
		logic [2:0] len;
		case (cmd)
			CMD_MOUNT:    len = 3'd4;
			CMD_OPEN:     len = 3'd1;
			CMD_OPENDIR:  len = 3'd1;
			CMD_OPENDIRX: len = 3'd3;
			CMD_LSEEK:    len = 3'd4;
			CMD_WRITE:    len = 3'd2;
			CMD_READ:     len = 3'd2;
			default:      len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic tnfs_step_t after_tail(
		input logic [7:0]       st,
		input logic [7:0]       cmd,
		input logic [7:0]       low,
		input logic [7:0]       cur,
		input logic [OFF_W-1:0] off,
		input tnfs_phase_t      ph,
		input logic [CNT_W-1:0] rem
	);
		tnfs_step_t       s;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W:0]   sum;
		s.phase     = ph;
		s.remaining = rem;
		s.res       = RES_NONE;
		cnt = {cur, low};
		sum = (CNT_W+1)'(off) + (CNT_W+1)'(1) + (CNT_W+1)'(cnt);
		if (st == ST_BUSY) begin
			s.res = RES_DONE;
		end else if (cmd == CMD_READ) begin
			if (sum > (CNT_W+1)'(MSG_CAP)) begin
				s.res = RES_OVF;
			end else if (cnt == '0) begin
				s.res = RES_DONE;
			end else begin
				s.phase     = PH_DATA;
				s.remaining = cnt;
			end
		end else if (cmd == CMD_READDIR) begin
			s.phase = PH_NAME;
		end else if (cmd == CMD_READDIRX) begin
			s.phase     = PH_XHDR;
			s.remaining = CNT_W'(4);
		end else begin
			s.res = RES_DONE;
		end
		return s;
	endfunction

	function automatic tnfs_step_t next_entry(
		input logic [7:0]       ent,
		input logic [OFF_W-1:0] off,
		input tnfs_phase_t      ph,
		input logic [CNT_W-1:0] rem
	);
		tnfs_step_t s;
		s.phase     = ph;
		s.remaining = rem;
		s.res       = RES_NONE;
		if (ent == 8'd0) begin
			s.res = RES_DONE;
		end else if ((OFF_W+1)'(off) + (OFF_W+1)'(1 + ENTRY_FIXED) > (OFF_W+1)'(MSG_CAP)) begin
			s.res = RES_OVF;
		end else begin
			s.phase     = PH_ENTRY;
			s.remaining = CNT_W'(ENTRY_FIXED);
		end
		return s;
	endfunction

endpackage

[src/tnfs_in_stage.sv]
// ----------------------------------------------------------------------------
// tnfs_in_stage
// Input register: holds one received byte and its command until it advances.
// ----------------------------------------------------------------------------
module tnfs_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           request_command,
	input  logic                 advance,
	output tnfs_pkg::tnfs_item_t item_s1
);
	import tnfs_pkg::*;

	logic load;

	assign load     = !item_s1.valid || advance;
	assign rx_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (load) begin
			item_s1.valid <= rx_valid;
			if (rx_valid) begin
				item_s1.data    <= rx_byte;
				item_s1.command <= request_command;
			end
		end
	end

endmodule

[src/tnfs_frame_core.sv]
// ----------------------------------------------------------------------------
// tnfs_frame_core
// Frame tracking state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module tnfs_frame_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  tnfs_pkg::tnfs_item_t   item_s1,
	output tnfs_pkg::tnfs_result_t result
);
	import tnfs_pkg::*;

	tnfs_phase_t      phase_q, phase_d;
	logic [OFF_W-1:0] total_q, total_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       st_q, st_d;
	logic [7:0]       low_q, low_d;
	logic [7:0]       ent_q, ent_d;

	always_comb begin
		logic [7:0]       b;
		logic [OFF_W-1:0] off;
		logic [1:0]       res;
		logic [2:0]       tail;
		tnfs_step_t       s;
		logic             at_cap;
		b       = item_s1.data;
		off     = total_q;
		res     = RES_NONE;
		phase_d = phase_q;
		rem_d   = rem_q;
		cmd_d   = cmd_q;
		st_d    = st_q;
		low_d   = low_q;
		ent_d   = ent_q;
		tail    = '0;
		s       = '{phase: phase_q, remaining: rem_q, res: RES_NONE};
		at_cap  = ((OFF_W+1)'(off) + (OFF_W+1)'(1)) >= (OFF_W+1)'(MSG_CAP);
		case (phase_q)
			PH_HEADER: begin
				if (off == '0) begin
					cmd_d = item_s1.command;
					st_d  = 8'd0;
				end
				if (off >= OFF_W'(4)) begin
					st_d = b;
					if (b == ST_BUSY) begin
						phase_d = PH_TAIL;
						rem_d   = CNT_W'(2);
					end else if (b == ST_OK || (cmd_d == CMD_READ && b == ST_EOF)) begin
						tail = tail_length(cmd_d);
						if (tail != '0) begin
							phase_d = PH_TAIL;
							rem_d   = CNT_W'(tail);
						end else begin
							s       = after_tail(st_d, cmd_d, low_d, 8'd0, off, phase_d, rem_d);
							phase_d = s.phase;
							rem_d   = s.remaining;
							res     = s.res;
							if (s.phase == PH_NAME) ent_d = 8'd0;
						end
					end else begin
						res = RES_DONE;
					end
				end
			end
			PH_TAIL: begin
				if (off == OFF_W'(5)) low_d = b;
				if (rem_d != '0) rem_d = rem_d - CNT_W'(1);
				if (rem_d == '0) begin
					s       = after_tail(st_d, cmd_d, low_d, b, off, phase_d, rem_d);
					phase_d = s.phase;
					rem_d   = s.remaining;
					res     = s.res;
					if (s.phase == PH_NAME) ent_d = 8'd0;
				end
			end
			PH_DATA: begin
				if (rem_d != '0) rem_d = rem_d - CNT_W'(1);
				if (rem_d == '0) res = RES_DONE;
			end
			PH_XHDR: begin
				if (rem_d == CNT_W'(4)) ent_d = b;
				if (rem_d != '0) rem_d = rem_d - CNT_W'(1);
				if (rem_d == '0) begin
					s       = next_entry(ent_d, off, phase_d, rem_d);
					phase_d = s.phase;
					rem_d   = s.remaining;
					res     = s.res;
				end
			end
			PH_ENTRY: begin
				if (rem_d != '0) rem_d = rem_d - CNT_W'(1);
				if (rem_d == '0) begin
					if (at_cap) res = RES_OVF;
					else phase_d = PH_NAME;
				end
			end
			PH_NAME: begin
				if (b == 8'd0) begin
					if (cmd_d == CMD_READDIRX) begin
						if (ent_d != 8'd0) ent_d = ent_d - 8'd1;
						s       = next_entry(ent_d, off, phase_d, rem_d);
						phase_d = s.phase;
						rem_d   = s.remaining;
						res     = s.res;
					end else begin
						res = RES_DONE;
					end
				end else if (at_cap) begin
					res = RES_OVF;
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase

		result.out_byte     = b;
		result.frame_offset = off;
		result.frame_last   = (res != RES_NONE);
		result.frame_result = res;
		result.reply_status = st_d;

		if (res != RES_NONE) begin
			phase_d = PH_HEADER;
			total_d = '0;
			rem_d   = '0;
			ent_d   = 8'd0;
		end else begin
			total_d = off + OFF_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			total_q <= '0;
			rem_q   <= '0;
			cmd_q   <= '0;
			st_q    <= '0;
			low_q   <= '0;
			ent_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			total_q <= total_d;
			rem_q   <= rem_d;
			cmd_q   <= cmd_d;
			st_q    <= st_d;
			low_q   <= low_d;
			ent_q   <= ent_d;
		end
	end

endmodule

[src/tnfs_out_stage.sv]
// ----------------------------------------------------------------------------
// tnfs_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module tnfs_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  tnfs_pkg::tnfs_result_t result,
	output logic                   free,
	output logic                   res_valid,
	input  logic                   res_stall,
	output tnfs_pkg::tnfs_result_t result_s2
);
	import tnfs_pkg::*;

	assign free = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (free) begin
			res_valid <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

[src/tnfs_tcp_response_deframer.sv]
// ----------------------------------------------------------------------------
// tnfs_tcp_response_deframer
// Marks reply frame boundaries in a TCP byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
// rx channel: rx_valid/rx_stall with rx_byte and request_command; the
//   command is only looked at on the first byte of each frame.
// res channel: res_valid/res_stall with out_byte, frame_offset, frame_last,
//   frame_result and reply_status, one result transfer per rx transfer,
//   in the same order.
// path: a byte lands in the input register, is decoded against the frame
//   state, and its result is registered in the result register, which raises
//   res_valid.
// throughput: one byte per cycle while the result channel is not stalled.
// stall: while the result register is full and stalled, one more byte is
//   held in the input register; after that rx_stall rises.
// reset: arst_n clears the input register and res_valid, not result data, and
//   puts the tracker at a frame start, all counts and captured status at zero.
// ----------------------------------------------------------------------------
module tnfs_tcp_response_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	output logic                       rx_stall,
	input  logic [7:0]                 rx_byte,
	input  logic [7:0]                 request_command,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [7:0]                 out_byte,
	output logic [tnfs_pkg::OFF_W-1:0] frame_offset,
	output logic                       frame_last,
	output logic [1:0]                 frame_result,
	output logic [7:0]                 reply_status
);
	import tnfs_pkg::*;

	tnfs_item_t   item_s1;
	tnfs_result_t result;
	tnfs_result_t result_s2;
	logic         free;
	logic         advance;

	assign advance = item_s1.valid && free;

	tnfs_in_stage u_in (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_valid        (rx_valid),
		.rx_stall        (rx_stall),
		.rx_byte         (rx_byte),
		.request_command (request_command),
		.advance         (advance),
		.item_s1         (item_s1)
	);

	tnfs_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	tnfs_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.result    (result),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.result_s2 (result_s2)
	);

	assign out_byte     = result_s2.out_byte;
	assign frame_offset = result_s2.frame_offset;
	assign frame_last   = result_s2.frame_last;
	assign frame_result = result_s2.frame_result;
	assign reply_status = result_s2.reply_status;

endmodule

[tb/tb_tnfs_tcp_response_deframer.sv]
// ----------------------------------------------------------------------------
// tb_tnfs_tcp_response_deframer
// Feeds TNFS reply byte streams into the deframer and checks every echoed byte,
// its frame offset, end marker, frame result and captured status against a
// frame tracker kept alongside the stimulus. Short hand-built replies come
// first, then frames that run up against the message capacity, then random
// replies with broken frames and random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tnfs_tcp_response_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import tnfs_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 600;
	localparam logic [7:0] KNOWN_CMDS [9] = '{CMD_MOUNT, CMD_OPEN, CMD_OPENDIR,
		CMD_OPENDIRX, CMD_LSEEK, CMD_WRITE, CMD_READ, CMD_READDIR, CMD_READDIRX};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             rx_valid = 1'b0;
	logic             rx_stall;
	logic [7:0]       rx_byte = 8'h00;
	logic [7:0]       request_command = 8'h00;
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [7:0]       out_byte;
	logic [OFF_W-1:0] frame_offset;
	logic             frame_last;
	logic [1:0]       frame_result;
	logic [7:0]       reply_status;

	// frame tracker state
	tnfs_phase_t      frm_phase = PH_HEADER;
	logic [OFF_W-1:0] frm_off = '0;
	logic [CNT_W-1:0] frm_left = '0;
	logic [7:0]       frm_cmd = '0;
	logic [7:0]       frm_status = '0;
	logic [7:0]       cnt_lo = '0;
	logic [7:0]       ents_left = '0;

	tnfs_result_t     frame_marks_q[$];
	tnfs_result_t     want;
	logic [7:0]       stream_q[$];
	int               items_sent = 0;
	int               mismatches = 0;
	int               idle_cycles = 0;
	int               stall_left = 0;
	bit               gap_on = 1'b1;
	bit               stall_on = 1'b1;

	tnfs_tcp_response_deframer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.request_command(request_command),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte(out_byte),
		.frame_offset(frame_offset),
		.frame_last(frame_last),
		.frame_result(frame_result),
		.reply_status(reply_status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 62)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [1:0] enter_body(input int off, input logic [7:0] cur);
		int cnt;
		cnt = int'({cur, cnt_lo});
		if (frm_status == ST_BUSY)
			return RES_DONE;
		if (frm_cmd == CMD_READ) begin
			if (off + 1 + cnt > MSG_CAP)
				return RES_OVF;
			if (cnt == 0)
				return RES_DONE;
			frm_phase = PH_DATA;
			frm_left = CNT_W'(cnt);
			return RES_NONE;
		end
		if (frm_cmd == CMD_READDIR) begin
			frm_phase = PH_NAME;
			ents_left = '0;
			return RES_NONE;
		end
		if (frm_cmd == CMD_READDIRX) begin
			frm_phase = PH_XHDR;
			frm_left = CNT_W'(4);
			return RES_NONE;
		end
		return RES_DONE;
	endfunction

	function automatic logic [1:0] next_record(input int off);
		if (ents_left == 8'd0)
			return RES_DONE;
		if (off + 1 + ENTRY_FIXED > MSG_CAP)
			return RES_OVF;
		frm_phase = PH_ENTRY;
		frm_left = CNT_W'(ENTRY_FIXED);
		return RES_NONE;
	endfunction

	function automatic tnfs_result_t track_frame(input logic [7:0] b, input logic [7:0] cmd);
		tnfs_result_t r;
		int off;
		int tail;
		logic [1:0] res;
		off = int'(frm_off);
		tail = 0;
		res = RES_NONE;
		case (frm_phase)
			PH_HEADER: begin
				if (off == 0) begin
					frm_cmd = cmd;
					frm_status = 8'h00;
				end
				if (off >= 4) begin
					frm_status = b;
					if (b == ST_BUSY) begin
						frm_phase = PH_TAIL;
						frm_left = CNT_W'(2);
					end else if (b == ST_OK || (frm_cmd == CMD_READ && b == ST_EOF)) begin
						case (frm_cmd)
							CMD_MOUNT, CMD_LSEEK:  tail = 4;
							CMD_OPENDIRX:          tail = 3;
							CMD_WRITE, CMD_READ:   tail = 2;
							CMD_OPEN, CMD_OPENDIR: tail = 1;
							default:               tail = 0;
						endcase
						if (tail != 0) begin
							frm_phase = PH_TAIL;
							frm_left = CNT_W'(tail);
						end else begin
							res = enter_body(off, 8'h00);
						end
					end else begin
						res = RES_DONE;
					end
				end
			end
			PH_TAIL: begin
				if (off == 5)
					cnt_lo = b;
				if (frm_left != 0)
					frm_left--;
				if (frm_left == 0)
					res = enter_body(off, b);
			end
			PH_DATA: begin
				if (frm_left != 0)
					frm_left--;
				if (frm_left == 0)
					res = RES_DONE;
			end
			PH_XHDR: begin
				if (frm_left == CNT_W'(4))
					ents_left = b;
				if (frm_left != 0)
					frm_left--;
				if (frm_left == 0)
					res = next_record(off);
			end
			PH_ENTRY: begin
				if (frm_left != 0)
					frm_left--;
				if (frm_left == 0) begin
					if (off + 1 >= MSG_CAP)
						res = RES_OVF;
					else
						frm_phase = PH_NAME;
				end
			end
			PH_NAME: begin
				if (b == 8'h00) begin
					if (frm_cmd == CMD_READDIRX) begin
						if (ents_left != 0)
							ents_left--;
						res = next_record(off);
					end else begin
						res = RES_DONE;
					end
				end else if (off + 1 >= MSG_CAP) begin
					res = RES_OVF;
				end
			end
			default: frm_phase = PH_HEADER;
		endcase
		r.out_byte = b;
		r.frame_offset = frm_off;
		r.frame_last = (res != RES_NONE);
		r.frame_result = res;
		r.reply_status = frm_status;
		if (res != RES_NONE) begin
			frm_phase = PH_HEADER;
			frm_off = '0;
			frm_left = '0;
			ents_left = '0;
		end else begin
			frm_off = frm_off + 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int exp_val, input int got_val);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch on %s: expected %0d, got %0d", what, exp_val, got_val);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic [7:0] cmd, output bit ends);
		int n;
		tnfs_result_t r;
		n = gap_on ? pick_idle() : 0;
		if (n > 0) begin
			rx_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		request_command <= cmd;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		r = track_frame(b, cmd);
		frame_marks_q.push_back(r);
		ends = r.frame_last;
		items_sent++;
	endtask

	task automatic push_name(input int name_len);
		int n;
		n = (name_len < 0) ? $urandom_range(0, 10) : name_len;
		repeat (n) stream_q.push_back(8'($urandom_range(1, 255)));
		stream_q.push_back(8'h00);
	endtask

	// fills stream_q with one reply; data or entries past the message capacity are not added
	task automatic build_reply(input logic [7:0] cmd, input logic [7:0] status,
			input int count, input int entries, input int name_len);
		int e;
		stream_q.delete();
		repeat (4) stream_q.push_back(8'($urandom));
		stream_q.push_back(status);
		if (status == ST_BUSY) begin
			repeat (2) stream_q.push_back(8'($urandom));
		end else if (status == ST_OK || (cmd == CMD_READ && status == ST_EOF)) begin
			case (cmd)
				CMD_MOUNT, CMD_LSEEK:  repeat (4) stream_q.push_back(8'($urandom));
				CMD_OPENDIRX:          repeat (3) stream_q.push_back(8'($urandom));
				CMD_WRITE:             repeat (2) stream_q.push_back(8'($urandom));
				CMD_OPEN, CMD_OPENDIR: stream_q.push_back(8'($urandom));
				CMD_READ: begin
					stream_q.push_back(count[7:0]);
					stream_q.push_back(count[15:8]);
					if (count <= MSG_CAP - 7)
						repeat (count) stream_q.push_back(8'($urandom));
				end
				CMD_READDIR: push_name(name_len);
				CMD_READDIRX: begin
					stream_q.push_back(entries[7:0]);
					repeat (3) stream_q.push_back(8'($urandom));
					for (e = 0; e < entries && stream_q.size() <= MSG_CAP; e++) begin
						repeat (ENTRY_FIXED) stream_q.push_back(8'($urandom));
						push_name(name_len);
					end
				end
				default: ;
			endcase
		end
	endtask

	// sends stream_q until the tracker sees the frame end or the bytes run out
	task automatic send_frame(input logic [7:0] cmd, input bit cmd_noise);
		bit ends;
		int i;
		ends = 1'b0;
		for (i = 0; i < stream_q.size() && !ends; i++)
			send_byte(stream_q[i], (i == 0 || !cmd_noise) ? cmd : 8'($urandom), ends);
	endtask

	task automatic test_status_handling();
		gap_on = 1'b1;
		stall_on = 1'b1;
		stream_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, ST_BUSY, 8'hFF, 8'h00};
		send_frame(CMD_MOUNT, 1'b0);
		stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame(CMD_READDIRX, 1'b1);
		// end-of-file status on a command other than read
		stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, ST_EOF};
		send_frame(CMD_WRITE, 1'b0);
	endtask

	task automatic test_read_counts();
		stream_q = '{8'hFF, 8'h00, 8'hFF, 8'h00, ST_OK, 8'h00, 8'h00};
		send_frame(CMD_READ, 1'b0);
		stream_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, ST_EOF, 8'hFF, 8'hFF};
		send_frame(CMD_READ, 1'b1);
	endtask

	task automatic test_capacity_edges();
		// read count one past what fits
		build_reply(CMD_READ, ST_EOF, MSG_CAP - 6, 0, 0);
		send_frame(CMD_READ, 1'b0);
		// second entry just fits, its fixed bytes end on the last offset
		build_reply(CMD_READDIRX, ST_OK, 0, 2, MSG_CAP - 36);
		send_frame(CMD_READDIRX, 1'b0);
	endtask

	task automatic test_random_replies();
		int goal;
		int k;
		int r;
		int n;
		int count;
		logic [7:0] cmd;
		logic [7:0] status;
		goal = items_sent + RANDOM_ITEMS;
		k = 0;
		while (items_sent < goal) begin
			gap_on = ($urandom_range(0, 99) >= 15);
			stall_on = ($urandom_range(0, 99) >= 15);
			if (k < 9)
				cmd = KNOWN_CMDS[k];
			else if ($urandom_range(0, 99) < 85)
				cmd = KNOWN_CMDS[$urandom_range(0, 8)];
			else
				cmd = 8'($urandom);
			r = $urandom_range(0, 99);
			if (r < 55)
				status = ST_OK;
			else if (r < 67)
				status = ST_BUSY;
			else if (r < 79)
				status = ST_EOF;
			else
				status = 8'($urandom);
			r = $urandom_range(0, 99);
			if (r < 75)
				count = $urandom_range(0, 20);
			else if (r < 85)
				count = 0;
			else if (r < 95)
				count = $urandom_range(MSG_CAP - 6, 65535);
			else
				count = 65535;
			build_reply(cmd, status, count, $urandom_range(0, 4), -1);
			// broken frames: cut short or with one byte replaced
			r = $urandom_range(0, 99);
			if (r < 6) begin
				n = $urandom_range(1, stream_q.size() - 1);
				repeat (n) void'(stream_q.pop_back());
			end else if (r < 12) begin
				stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom);
			end
			send_frame(cmd, 1'($urandom_range(0, 1)));
			k++;
		end
	endtask

	always @(posedge clk) begin
		if (!stall_on) begin
			stall_left = 0;
			res_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			stall_left = pick_idle();
			res_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (frame_marks_q.size() == 0) begin
				report_mismatch("result with nothing pending", 0, out_byte);
			end else begin
				want = frame_marks_q.pop_front();
				if (out_byte !== want.out_byte)
					report_mismatch("out_byte", want.out_byte, out_byte);
				if (frame_offset !== want.frame_offset)
					report_mismatch("frame_offset", want.frame_offset, frame_offset);
				if (frame_last !== want.frame_last)
					report_mismatch("frame_last", want.frame_last, frame_last);
				if (frame_result !== want.frame_result)
					report_mismatch("frame_result", want.frame_result, frame_result);
				if (reply_status !== want.reply_status)
					report_mismatch("reply_status", want.reply_status, reply_status);
			end
		end
	end

	always @(posedge clk) begin
		if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_status_handling();
		test_read_counts();
		test_capacity_edges();
		test_random_replies();
		rx_valid <= 1'b0;
		while (frame_marks_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
